@@ hw/rtl/ovn_pkg.sv @@
// Shared constants and interface structs for the octave value noise block.
// No dependencies; imported by every module of the block.
package ovn_pkg;

    localparam int C_GRID_BITS  = 8;                      // grid is 2**C_GRID_BITS square
    localparam int C_ADDR_W     = 2 * C_GRID_BITS;        // row-major {row, column}
    localparam int C_PITCH_W    = C_GRID_BITS + 1;        // pitch up to the grid size
    localparam int C_SHIFT_W    = $clog2(C_GRID_BITS + 1);
    localparam int C_SEED_W     = 16;
    localparam int C_OCT_W      = 4;
    localparam int C_BIAS_W     = 16;
    localparam int C_SCALE_W    = 32;
    localparam int C_PROD_W     = C_SEED_W + C_SCALE_W;
    localparam int C_ACC_N_W    = C_PROD_W + C_OCT_W;     // up to 15 weighted octaves
    localparam int C_ACC_S_W    = C_SCALE_W + C_OCT_W;
    localparam int C_DIV_BITS_W = C_SCALE_W + 8;          // scale * 256
    localparam int C_DIV_CNT_W  = $clog2(C_DIV_BITS_W + 1);
    localparam int C_TERM_W     = C_SEED_W + C_GRID_BITS; // one interpolated row
    localparam int C_SUM_W      = C_SEED_W + C_ADDR_W;    // both rows, before the shift

    localparam logic [C_SCALE_W-1:0]   C_SCALE_ONE      = C_SCALE_W'(65536);
    localparam logic [C_OCT_W-1:0]     C_COUNT_RESET    = C_OCT_W'(8);
    localparam logic [C_BIAS_W-1:0]    C_BIAS_RESET     = C_BIAS_W'(512);
    localparam logic [C_DIV_CNT_W-1:0] C_SCALE_DIV_STEPS = C_DIV_CNT_W'(C_DIV_BITS_W);
    localparam logic [C_DIV_CNT_W-1:0] C_FIN_DIV_STEPS   = C_DIV_CNT_W'(C_SEED_W);

    typedef struct packed {
        logic                we;
        logic                re;
        logic [C_ADDR_W-1:0] addr;
        logic [C_SEED_W-1:0] wdata;
    } t_mem_req;

    typedef struct packed {
        logic                   start;
        logic [C_GRID_BITS-1:0] pos_x;
        logic [C_GRID_BITS-1:0] pos_y;
        logic [C_OCT_W-1:0]     oct;
    } t_oct_req;

    typedef struct packed {
        logic                done;
        logic [C_SEED_W-1:0] value;
    } t_oct_rsp;

    typedef struct packed {
        logic                    start;
        logic [C_ACC_S_W-1:0]    rem_init;  // must be below the divisor
        logic [C_DIV_BITS_W-1:0] bits;      // dividend bits, MSB first
        logic [C_DIV_CNT_W-1:0]  count;     // quotient bits to produce
        logic [C_ACC_S_W-1:0]    divisor;
    } t_div_req;

    typedef struct packed {
        logic                    done;
        logic [C_DIV_BITS_W-1:0] quot;
    } t_div_rsp;

endpackage

@@ hw/rtl/octave_value_noise_2d.sv @@
// Top level of the octave value noise block: command port, config registers,
// octave sequencer and accumulators. Depends on ovn_pkg, ovn_seed_ram,
// ovn_divider and ovn_octave.
//
// Usage:
//   Commands are transferred on a rising edge with start high and busy low.
//   A write (operation 0) stores seed_value at (pos_x, pos_y) in that same
//   edge; busy stays low and no result follows.
//   A query (operation 1) raises busy; the noise value appears on
//   o_noise_value with o_valid high for exactly one cycle, and busy drops
//   in that same cycle. The receiver cannot stall: o_valid is gone after
//   that cycle, while o_noise_value holds until the next result.
//   Each octave but the last waits on the next-scale division (40 quotient
//   bits, one per cycle); the last octave waits only on its 4 seed reads
//   and 3 multiply steps; the final normalize division comes after that.
//   Config writes on i_cfg_we take effect at once; write them while idle.
//   Reset sets octave_count to 8 and octave_bias to 2.0; the seed table is
//   not cleared and must be written before it is queried.
module octave_value_noise_2d
    import ovn_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   i_operation,
    input  logic [C_GRID_BITS-1:0] i_pos_x,
    input  logic [C_GRID_BITS-1:0] i_pos_y,
    input  logic [C_SEED_W-1:0]    i_seed_value,
    input  logic                   i_cfg_we,
    input  logic [0:0]             i_cfg_index,
    input  logic [C_BIAS_W-1:0]    i_cfg_data,
    output logic                   o_valid,
    output logic [C_SEED_W-1:0]    o_noise_value
);

    localparam logic [0:0] REG_OCTAVE_COUNT = 1'b0;
    localparam logic [0:0] REG_OCTAVE_BIAS  = 1'b1;
    localparam logic       OP_WRITE         = 1'b0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_OCT_GO,
        S_OCT_WAIT,
        S_ACC,
        S_FIN_GO,
        S_FIN_WAIT
    } t_state;

    t_state                 r_state;
    logic [C_OCT_W-1:0]     r_octave_count;
    logic [C_BIAS_W-1:0]    r_octave_bias;
    logic [C_OCT_W-1:0]     r_cnt_eff;
    logic [C_BIAS_W-1:0]    r_bias_eff;
    logic [C_OCT_W-1:0]     r_oct;
    logic [C_GRID_BITS-1:0] r_x, r_y;
    logic [C_SCALE_W-1:0]   r_scale;
    logic [C_PROD_W-1:0]    r_prod;
    logic [C_ACC_N_W-1:0]   r_acc_noise;
    logic [C_ACC_S_W-1:0]   r_acc_scale;
    logic                   r_v_ok, r_q_ok;
    logic                   r_valid;
    logic [C_SEED_W-1:0]    r_noise;

    logic                   n_accept;
    logic                   n_last;
    logic [C_SCALE_W-1:0]   n_scale_sat;
    logic [C_SEED_W-1:0]    n_noise_sat;

    t_mem_req               mem_req;
    t_mem_req               oct_mem;
    logic [C_SEED_W-1:0]    mem_rdata;
    t_oct_req               oct_req;
    t_oct_rsp               oct_rsp;
    t_div_req               div_req;
    t_div_rsp               div_rsp;

    assign busy     = (r_state != S_IDLE);
    assign n_accept = start && !busy;
    assign n_last   = (C_OCT_W'(r_oct + 1'b1) == r_cnt_eff);

    always_comb begin
        n_scale_sat = (|div_rsp.quot[C_DIV_BITS_W-1:C_SCALE_W]) ? '1
                                                                : div_rsp.quot[C_SCALE_W-1:0];
        n_noise_sat = (|div_rsp.quot[C_DIV_BITS_W-1:C_SEED_W]) ? '1
                                                               : div_rsp.quot[C_SEED_W-1:0];
    end

    // seed writes only happen while idle, so the port is never contended
    always_comb begin
        if (n_accept && i_operation == OP_WRITE) begin
            mem_req.we    = 1'b1;
            mem_req.re    = 1'b0;
            mem_req.addr  = {i_pos_y, i_pos_x};
            mem_req.wdata = i_seed_value;
        end else begin
            mem_req = oct_mem;
        end
    end

    assign oct_req.start = (r_state == S_OCT_GO);
    assign oct_req.pos_x = r_x;
    assign oct_req.pos_y = r_y;
    assign oct_req.oct   = r_oct;

    always_comb begin
        if (r_state == S_FIN_GO) begin
            div_req.start    = 1'b1;
            div_req.rem_init = r_acc_noise[C_ACC_N_W-1:C_SEED_W];
            div_req.bits     = {r_acc_noise[C_SEED_W-1:0], (C_DIV_BITS_W-C_SEED_W)'(0)};
            div_req.count    = C_FIN_DIV_STEPS;
            div_req.divisor  = r_acc_scale;
        end else begin
            // next scale = scale * 256 / bias; not needed after the last octave
            div_req.start    = (r_state == S_OCT_GO) && !n_last;
            div_req.rem_init = '0;
            div_req.bits     = {r_scale, 8'd0};
            div_req.count    = C_SCALE_DIV_STEPS;
            div_req.divisor  = C_ACC_S_W'(r_bias_eff);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_octave_count <= C_COUNT_RESET;
            r_octave_bias  <= C_BIAS_RESET;
            r_v_ok         <= 1'b0;
            r_q_ok         <= 1'b0;
            r_valid        <= 1'b0;
        end else begin
            r_valid <= (r_state == S_FIN_WAIT) && div_rsp.done;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_OCTAVE_COUNT: r_octave_count <= i_cfg_data[C_OCT_W-1:0];
                    REG_OCTAVE_BIAS:  r_octave_bias  <= i_cfg_data;
                    default:          ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (n_accept && i_operation != OP_WRITE) begin
                        r_x         <= i_pos_x;
                        r_y         <= i_pos_y;
                        r_cnt_eff   <= (r_octave_count == '0) ? C_OCT_W'(1) : r_octave_count;
                        r_bias_eff  <= (r_octave_bias == '0) ? C_BIAS_W'(1) : r_octave_bias;
                        r_oct       <= '0;
                        r_scale     <= C_SCALE_ONE;
                        r_acc_noise <= '0;
                        r_acc_scale <= '0;
                        r_state     <= S_OCT_GO;
                    end
                end
                S_OCT_GO: begin
                    r_v_ok  <= 1'b0;
                    r_q_ok  <= n_last;
                    r_state <= S_OCT_WAIT;
                end
                S_OCT_WAIT: begin
                    if (oct_rsp.done) begin
                        r_prod <= oct_rsp.value * r_scale;
                        r_v_ok <= 1'b1;
                    end
                    if (div_rsp.done) begin
                        r_q_ok <= 1'b1;
                    end
                    if (r_v_ok && r_q_ok) begin
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    r_acc_noise <= r_acc_noise + C_ACC_N_W'(r_prod);
                    r_acc_scale <= r_acc_scale + C_ACC_S_W'(r_scale);
                    if (n_last) begin
                        r_state <= S_FIN_GO;
                    end else begin
                        r_scale <= n_scale_sat;
                        r_oct   <= r_oct + 1'b1;
                        r_state <= S_OCT_GO;
                    end
                end
                S_FIN_GO: begin
                    r_state <= S_FIN_WAIT;
                end
                S_FIN_WAIT: begin
                    if (div_rsp.done) begin
                        r_noise <= n_noise_sat;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid       = r_valid;
    assign o_noise_value = r_noise;

    ovn_seed_ram u_seed_ram (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    ovn_octave u_octave (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (oct_req),
        .i_rdata (mem_rdata),
        .o_mem   (oct_mem),
        .o_rsp   (oct_rsp)
    );

    ovn_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

endmodule

@@ hw/rtl/ovn_seed_ram.sv @@
// Seed table: single-port synchronous RAM with a registered read.
// Depends on ovn_pkg for widths and the request struct.
module ovn_seed_ram
    import ovn_pkg::*;
(
    input  logic                i_clk,
    input  t_mem_req            i_req,
    output logic [C_SEED_W-1:0] o_rdata
);

    logic [C_SEED_W-1:0] r_mem [2**C_ADDR_W];
    logic [C_SEED_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/ovn_divider.sv @@
// Shared restoring divider, one quotient bit per cycle.
// Depends on ovn_pkg. Used for the per-octave scale and the final normalize.
module ovn_divider
    import ovn_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                    r_busy;
    logic                    r_done;
    logic [C_DIV_CNT_W-1:0]  r_cnt;
    logic [C_ACC_S_W-1:0]    r_rem;
    logic [C_DIV_BITS_W-1:0] r_bits;
    logic [C_DIV_BITS_W-1:0] r_quot;
    logic [C_ACC_S_W-1:0]    r_div;

    logic [C_ACC_S_W:0]      n_trial;
    logic [C_ACC_S_W+1:0]    n_diff;
    logic                    n_qbit;

    always_comb begin
        n_trial = {r_rem, r_bits[C_DIV_BITS_W-1]};
        n_diff  = {1'b0, n_trial} - {2'b00, r_div};
        n_qbit  = ~n_diff[C_ACC_S_W+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_req.start && r_busy && (r_cnt == C_DIV_CNT_W'(1));
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.count;
                r_rem  <= i_req.rem_init;
                r_bits <= i_req.bits;
                r_div  <= i_req.divisor;
                r_quot <= '0;
            end else if (r_busy) begin
                // remainder stays below the divisor, so it fits after the subtract
                r_rem  <= n_qbit ? n_diff[C_ACC_S_W-1:0] : n_trial[C_ACC_S_W-1:0];
                r_bits <= {r_bits[C_DIV_BITS_W-2:0], 1'b0};
                r_quot <= {r_quot[C_DIV_BITS_W-2:0], n_qbit};
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == C_DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

@@ hw/rtl/ovn_octave.sv @@
// One octave: four corner reads from the seed table and bilinear interpolation.
// Depends on ovn_pkg; drives the read side of ovn_seed_ram through the top level.
module ovn_octave
    import ovn_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_oct_req            i_req,
    input  logic [C_SEED_W-1:0] i_rdata,
    output t_mem_req            o_mem,
    output t_oct_rsp            o_rsp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_T,
        S_B,
        S_V,
        S_OUT
    } t_state;

    t_state                 r_state;
    logic [1:0]             r_rd_cnt;
    logic                   r_cap_en;
    logic [1:0]             r_cap_idx;
    logic [C_SEED_W-1:0]    r_seed [4];
    logic [C_SHIFT_W-1:0]   r_k;
    logic [C_PITCH_W-1:0]   r_p;
    logic [C_GRID_BITS-1:0] r_x1, r_x2, r_y1, r_y2, r_bx, r_by;
    logic [C_TERM_W-1:0]    r_t, r_b;
    logic [C_SUM_W-1:0]     r_sum;
    logic                   r_done;
    logic [C_SEED_W-1:0]    r_value;

    logic [C_SHIFT_W-1:0]   n_k;
    logic [C_PITCH_W-1:0]   n_p;
    logic [C_GRID_BITS-1:0] n_mask;
    logic [C_GRID_BITS-1:0] n_x1, n_y1;
    logic [C_PITCH_W-1:0]   n_pbx, n_pby;
    logic [C_TERM_W:0]      n_row;
    logic [C_SUM_W:0]       n_col;
    logic [C_ADDR_W-1:0]    n_addr;

    // pitch = grid >> oct, held at 1 once the shift passes the grid size
    always_comb begin
        if (i_req.oct >= C_OCT_W'(C_GRID_BITS)) begin
            n_k = '0;
        end else begin
            n_k = C_SHIFT_W'(C_GRID_BITS) - C_SHIFT_W'(i_req.oct);
        end
        n_p    = C_PITCH_W'(1) << n_k;
        n_mask = C_GRID_BITS'(n_p - C_PITCH_W'(1));
        n_x1   = i_req.pos_x & ~n_mask;
        n_y1   = i_req.pos_y & ~n_mask;
    end

    always_comb begin
        n_pbx = r_p - C_PITCH_W'(r_bx);
        n_pby = r_p - C_PITCH_W'(r_by);
        if (r_state == S_T) begin
            n_row = (C_TERM_W+1)'(n_pbx * r_seed[0]) + (C_TERM_W+1)'(r_bx * r_seed[1]);
        end else begin
            n_row = (C_TERM_W+1)'(n_pbx * r_seed[2]) + (C_TERM_W+1)'(r_bx * r_seed[3]);
        end
        n_col = (C_SUM_W+1)'(n_pby * r_t) + (C_SUM_W+1)'(r_by * r_b);
    end

    always_comb begin
        case (r_rd_cnt)
            2'd0:    n_addr = {r_y1, r_x1};
            2'd1:    n_addr = {r_y1, r_x2};
            2'd2:    n_addr = {r_y2, r_x1};
            default: n_addr = {r_y2, r_x2};
        endcase
    end

    assign o_mem.we    = 1'b0;
    assign o_mem.re    = (r_state == S_RD);
    assign o_mem.addr  = n_addr;
    assign o_mem.wdata = '0;

    always_ff @(posedge i_clk) begin
        if (r_cap_en) begin
            r_seed[r_cap_idx] <= i_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rd_cnt <= '0;
            r_cap_en <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_done    <= (r_state == S_OUT);
            r_cap_en  <= (r_state == S_RD);
            r_cap_idx <= r_rd_cnt;
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.start) begin
                        r_k      <= n_k;
                        r_p      <= n_p;
                        r_x1     <= n_x1;
                        r_y1     <= n_y1;
                        r_x2     <= C_GRID_BITS'(n_x1 + n_p);
                        r_y2     <= C_GRID_BITS'(n_y1 + n_p);
                        r_bx     <= i_req.pos_x & n_mask;
                        r_by     <= i_req.pos_y & n_mask;
                        r_rd_cnt <= '0;
                        r_state  <= S_RD;
                    end
                end
                S_RD: begin
                    r_rd_cnt <= r_rd_cnt + 2'd1;
                    if (r_rd_cnt == 2'd3) begin
                        r_state <= S_T;
                    end
                end
                S_T: begin
                    r_t     <= C_TERM_W'(n_row);
                    r_state <= S_B;
                end
                S_B: begin
                    r_b     <= C_TERM_W'(n_row);
                    r_state <= S_V;
                end
                S_V: begin
                    r_sum   <= C_SUM_W'(n_col);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // divide by pitch squared: pitch is 2**k
                    r_value <= C_SEED_W'(r_sum >> {r_k, 1'b0});
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.value = r_value;

endmodule

@@ tb/sv/octave_value_noise_2d_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for octave_value_noise_2d: seed writes, noise queries, config.
// Depends on ovn_pkg and the octave_value_noise_2d RTL with its submodules.
module octave_value_noise_2d_test;
    import ovn_pkg::*;

    localparam int GRID          = 1 << C_GRID_BITS;
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 800;     // longer than a 15-octave query
    localparam int PHASES        = 10;
    localparam int PHASE_ITEMS   = 70;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [0:0] REG_OCT_COUNT = 1'b0;
    localparam logic [0:0] REG_OCT_BIAS  = 1'b1;

    typedef struct {
        logic                   op;
        logic [C_GRID_BITS-1:0] x;
        logic [C_GRID_BITS-1:0] y;
        logic [C_SEED_W-1:0]    seed;
        bit                     hold;   // wait for every pending result first
    } t_noise_cmd;

    logic                   i_clk        = 1'b0;
    logic                   i_rst_n      = 1'b0;
    logic                   start        = 1'b0;
    logic                   busy;
    logic                   i_operation  = OP_WRITE;
    logic [C_GRID_BITS-1:0] i_pos_x      = '0;
    logic [C_GRID_BITS-1:0] i_pos_y      = '0;
    logic [C_SEED_W-1:0]    i_seed_value = '0;
    logic                   i_cfg_we     = 1'b0;
    logic [0:0]             i_cfg_index  = REG_OCT_COUNT;
    logic [C_BIAS_W-1:0]    i_cfg_data   = '0;
    logic                   o_valid;
    logic [C_SEED_W-1:0]    o_noise_value;

    octave_value_noise_2d i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_operation   (i_operation),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_seed_value  (i_seed_value),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_valid       (o_valid),
        .o_noise_value (o_noise_value)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Mirror of the block state, updated on each transfer and config write.
    logic [C_SEED_W-1:0] seeds [GRID*GRID];
    logic [C_OCT_W-1:0]  oct_count = C_COUNT_RESET;
    logic [C_BIAS_W-1:0] oct_bias  = C_BIAS_RESET;

    // Entries the stimulus has already scheduled a write for.
    bit                  filled [GRID*GRID];

    t_noise_cmd          cmd_backlog [$];
    logic [C_SEED_W-1:0] noise_due [$];
    t_noise_cmd          cur_cmd;
    bit                  have_cur   = 1'b0;
    int                  gap_left   = 0;
    int                  idle_pct   = 0;
    int                  planned    = 0;
    int                  mismatches = 0;
    int                  cycles     = 0;
    logic [C_GRID_BITS-1:0] hot_x = '0;
    logic [C_GRID_BITS-1:0] hot_y = '0;

    function automatic int unsigned pitch_of(input int unsigned o);
        return (o <= C_GRID_BITS) ? (GRID >> o) : 1;
    endfunction

    // Bilinear blend of the four pitch-aligned corners, truncated to Q0.16.
    function automatic longint unsigned octave_blend(input int unsigned x, input int unsigned y,
                                                     input int unsigned o);
        longint unsigned p, x1, y1, x2, y2, bx, by, top, bot;
        p   = pitch_of(o);
        x1  = (x / p) * p;
        y1  = (y / p) * p;
        x2  = (x1 + p) % GRID;
        y2  = (y1 + p) % GRID;
        bx  = x - x1;
        by  = y - y1;
        top = (p - bx) * seeds[y1 * GRID + x1] + bx * seeds[y1 * GRID + x2];
        bot = (p - bx) * seeds[y2 * GRID + x1] + bx * seeds[y2 * GRID + x2];
        return ((p - by) * top + by * bot) / (p * p);
    endfunction

    function automatic logic [C_SEED_W-1:0] noise_at(input int unsigned x, input int unsigned y);
        longint unsigned scale, acc_n, acc_s, q;
        int unsigned n_oct, div, o;
        scale = C_SCALE_ONE;
        acc_n = 0;
        acc_s = 0;
        n_oct = (oct_count == 0) ? 1 : oct_count;
        div   = (oct_bias == 0) ? 1 : oct_bias;
        for (o = 0; o < n_oct; o++) begin
            acc_n += octave_blend(x, y, o) * scale;
            acc_s += scale;
            scale = (scale * 256) / div;
            if (scale > 64'hFFFF_FFFF) scale = 64'hFFFF_FFFF;
        end
        q = acc_n / acc_s;
        return (q > 65535) ? 16'hFFFF : q[C_SEED_W-1:0];
    endfunction

    task automatic flag_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        mismatches++;
    endtask

    function automatic logic [C_SEED_W-1:0] pick_seed();
        int unsigned r;
        r = $urandom_range(9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return C_SEED_W'($urandom);
    endfunction

    task automatic queue_write(input logic [C_GRID_BITS-1:0] x, input logic [C_GRID_BITS-1:0] y,
                               input logic [C_SEED_W-1:0] seed);
        t_noise_cmd c;
        c.op   = OP_WRITE;
        c.x    = x;
        c.y    = y;
        c.seed = seed;
        c.hold = 1'b0;
        cmd_backlog.push_back(c);
        filled[{y, x}] = 1'b1;
        planned++;
    endtask

    task automatic fill_entry(input int unsigned x, input int unsigned y);
        if (!filled[y * GRID + x]) queue_write(C_GRID_BITS'(x), C_GRID_BITS'(y), pick_seed());
    endtask

    // Any octave count reads corners from octaves 0..C_GRID_BITS only; all are
    // written first so a query never touches an unwritten entry.
    task automatic queue_query(input logic [C_GRID_BITS-1:0] qx, input logic [C_GRID_BITS-1:0] qy,
                               input bit hold);
        t_noise_cmd c;
        int unsigned o, p, x1, y1, x2, y2;
        for (o = 0; o <= C_GRID_BITS; o++) begin
            p  = pitch_of(o);
            x1 = (qx / p) * p;
            y1 = (qy / p) * p;
            x2 = (x1 + p) % GRID;
            y2 = (y1 + p) % GRID;
            fill_entry(x1, y1);
            fill_entry(x2, y1);
            fill_entry(x1, y2);
            fill_entry(x2, y2);
        end
        c.op   = OP_QUERY;
        c.x    = qx;
        c.y    = qy;
        c.seed = C_SEED_W'($urandom);   // ignored by queries
        c.hold = hold;
        cmd_backlog.push_back(c);
        hot_x = qx;
        hot_y = qy;
        planned++;
    endtask

    function automatic logic [C_GRID_BITS-1:0] near(input logic [C_GRID_BITS-1:0] base);
        return C_GRID_BITS'(base + $urandom_range(6) - 3);
    endfunction

    task automatic queue_random(input int n);
        int stop_at;
        int unsigned sel;
        logic [C_GRID_BITS-1:0] x, y;
        stop_at = planned + n;
        while (planned < stop_at) begin
            sel = $urandom_range(99);
            if (sel < 35) begin
                if (sel < 18) begin
                    x = near(hot_x);
                    y = near(hot_y);
                end else begin
                    x = C_GRID_BITS'($urandom);
                    y = C_GRID_BITS'($urandom);
                end
                queue_write(x, y, pick_seed());
            end else begin
                case ($urandom_range(3))
                    0, 1: begin
                        x = near(hot_x);
                        y = near(hot_y);
                    end
                    2: begin
                        x = $urandom_range(1) ? '1 : '0;
                        y = $urandom_range(1) ? '1 : C_GRID_BITS'($urandom);
                    end
                    default: begin
                        x = C_GRID_BITS'($urandom);
                        y = C_GRID_BITS'($urandom);
                    end
                endcase
                queue_query(x, y, $urandom_range(99) < 3);
            end
        end
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [C_BIAS_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == REG_OCT_COUNT) oct_count = data[C_OCT_W-1:0];
        else oct_bias = data;
    endtask

    task automatic settle();
        while (cmd_backlog.size() > 0 || have_cur || noise_due.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Driver: a transfer happens on an edge with start high and busy low.
    always @(posedge i_clk) begin : driver
        if (!i_rst_n) begin
            start    <= 1'b0;
            have_cur = 1'b0;
            gap_left = 0;
        end else begin
            if (start && !busy) begin
                if (cur_cmd.op == OP_WRITE) seeds[{cur_cmd.y, cur_cmd.x}] = cur_cmd.seed;
                else noise_due.push_back(noise_at(cur_cmd.x, cur_cmd.y));
                have_cur = 1'b0;
            end
            if (gap_left > 0) gap_left--;
            else if (idle_pct > 0 && $urandom_range(99) < idle_pct)
                gap_left = $urandom_range(1, 18);
            if (!have_cur && cmd_backlog.size() > 0 &&
                !(cmd_backlog[0].hold && noise_due.size() > 0)) begin
                cur_cmd = cmd_backlog.pop_front();
                have_cur = 1'b1;
                i_operation  <= cur_cmd.op;
                i_pos_x      <= cur_cmd.x;
                i_pos_y      <= cur_cmd.y;
                i_seed_value <= cur_cmd.seed;
            end
            start <= have_cur && gap_left == 0;
        end
    end

    // Monitor: results cannot be stalled, so each strobe is one transfer.
    always @(posedge i_clk) begin : monitor
        logic [C_SEED_W-1:0] want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (noise_due.size() == 0) begin
                flag_mismatch($sformatf("result %h with no query pending", o_noise_value));
            end else begin
                want = noise_due.pop_front();
                if (o_noise_value !== want)
                    flag_mismatch($sformatf("noise_value got %h expected %h",
                                            o_noise_value, want));
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     noise_due.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin : main
        int p;
        logic [C_OCT_W-1:0]  cnt;
        logic [C_BIAS_W-1:0] bias, cnt_word;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset config: corner points, extreme seeds, overwrite.
        idle_pct = 10;
        queue_write('0, '0, '1);
        queue_write('1, '1, '0);
        queue_query('0, '0, 1'b0);
        queue_query('1, '1, 1'b0);
        queue_query('1, '0, 1'b0);
        queue_query('0, '1, 1'b0);
        queue_write('0, '0, '0);
        queue_query('0, '0, 1'b1);
        queue_query(8'd128, 8'd64, 1'b0);
        queue_query(8'd1, 8'd254, 1'b0);
        queue_query(8'hAA, 8'h55, 1'b0);

        for (p = 0; p < PHASES; p++) begin
            case (p)
                0: begin cnt = 4'd1;  bias = 16'd256;  end
                1: begin cnt = 4'd15; bias = 16'd0;    end   // zero bias, pitch floors at 1
                2: begin cnt = 4'd0;  bias = 16'hFFFF; end   // zero count runs one octave
                3: begin cnt = 4'd8;  bias = 16'd1;    end
                4: begin cnt = 4'd4;  bias = 16'd384;  end
                default: begin
                    cnt  = ($urandom_range(3) == 0) ? C_OCT_W'($urandom_range(15))
                                                    : C_OCT_W'($urandom_range(1, 8));
                    bias = ($urandom_range(2) == 0) ? C_BIAS_W'($urandom)
                                                    : C_BIAS_W'($urandom_range(64, 1024));
                end
            endcase
            settle();
            cnt_word = C_BIAS_W'($urandom);
            cnt_word[C_OCT_W-1:0] = cnt;            // upper bits are don't-care
            write_reg(REG_OCT_COUNT, cnt_word);
            write_reg(REG_OCT_BIAS, bias);
            idle_pct = (p % 3 == 2 || p == PHASES - 1) ? 0 : $urandom_range(3, 20);
            queue_random(PHASE_ITEMS);
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
